[rtl/gtg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gtg_pkg: shared types and constants of the go-to-goal controller
// Fixed-point widths, CORDIC arctangent table, beat and register formats.
// ----------------------------------------------------------------------------
package gtg_pkg;

   // field widths
   localparam int POS_W   = 16;  // Q6.10 positions
   localparam int HD_W    = 16;  // Q3.13 heading
   localparam int GAIN_W  = 16;  // Q2.14 gains
   localparam int SPD_W   = 15;  // Q5.10 unsigned speeds and distance
   localparam int ANG_W   = 16;  // Q6.10 signed turn rate
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   // cordic datapath widths
   localparam int DIFF_W = POS_W + 1;   // goal minus pose
   localparam int XY_W   = 28;          // dx*256 plus cordic growth
   localparam int Z_W    = 21;          // Q.16 angle with pre-rotation
   localparam int TAB_N  = 24;

   localparam logic signed [Z_W-1:0] PI_Q16 = 21'sd205887;

   localparam logic signed [Z_W-1:0] ATAN_TAB [TAB_N] = '{
      21'sd51472, 21'sd30385, 21'sd16055, 21'sd8150, 21'sd4091, 21'sd2047,
      21'sd1024,  21'sd512,   21'sd256,   21'sd128,  21'sd64,   21'sd32,
      21'sd16,    21'sd8,     21'sd4,     21'sd2,    21'sd1,    21'sd0,
      21'sd0,     21'sd0,     21'sd0,     21'sd0,    21'sd0,    21'sd0
   };

   // cordic gain compensation 0.6072529 in Q0.24
   localparam int PROD_W = XY_W + 25;
   localparam logic signed [PROD_W-1:0] GAIN_COMP = 53'sd10188014;
   localparam logic signed [PROD_W-1:0] DIST_RND  = 53'sd2147483648;

   // post-processing widths
   localparam int BRG_W   = Z_W - 3;          // Q5.13 bearing
   localparam int ERR_W   = BRG_W + 1;        // bearing minus heading
   localparam int LINP_W  = SPD_W + GAIN_W;   // distance times gain
   localparam int ANGP_W  = ERR_W + GAIN_W + 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_X       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_Y       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LINEAR_GAIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGULAR_GAIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_LIMIT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ARRIVE_THR   = 3'd5;

   // data handed from cell to cell
   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic signed [HD_W-1:0] hd;
   } cordic_type;

   // settings used after the cordic chain
   typedef struct packed {
      logic [GAIN_W-1:0] linear_gain;
      logic [GAIN_W-1:0] angular_gain;
      logic [SPD_W-1:0]  speed_limit;
      logic [SPD_W-1:0]  arrive_threshold;
   } cfg_type;

   // one result beat
   typedef struct packed {
      logic [SPD_W-1:0]        linear_speed;
      logic signed [ANG_W-1:0] angular_speed;
      logic                    reached;
      logic [SPD_W-1:0]        distance;
   } rsp_type;

endpackage
`default_nettype wire

[rtl/gtg_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gtg_req_if: pose request channel
// Valid/ready channel carrying one robot pose per beat.
// ----------------------------------------------------------------------------
interface gtg_req_if import gtg_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] pos_x;
   logic signed [POS_W-1:0] pos_y;
   logic signed [HD_W-1:0]  heading;

   modport source (output valid, pos_x, pos_y, heading, input ready);
   modport sink   (input valid, pos_x, pos_y, heading, output ready);
endinterface
`default_nettype wire

[rtl/gtg_rsp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gtg_rsp_if: speed command channel
// Valid/ready channel carrying one speed command per beat.
// ----------------------------------------------------------------------------
interface gtg_rsp_if import gtg_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [SPD_W-1:0]        linear_speed;
   logic signed [ANG_W-1:0] angular_speed;
   logic                    reached;
   logic [SPD_W-1:0]        distance;

   modport source (output valid, linear_speed, angular_speed, reached, distance,
                   input ready);
   modport sink   (input valid, linear_speed, angular_speed, reached, distance,
                   output ready);
endinterface
`default_nettype wire

[rtl/gtg_cordic_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gtg_cordic_cell: one vectoring cordic micro-rotation
// Holds one beat, rotates it by atan(2^-STAGE) toward the x axis.
// ----------------------------------------------------------------------------
module gtg_cordic_cell
   import gtg_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire cordic_type in_data,
   output logic            out_valid,
   input  wire logic       out_ready,
   output cordic_type      out_data
);

   logic                   valid_ff;
   cordic_type             data_ff;
   cordic_type             data_in;
   logic signed [XY_W-1:0] xs;
   logic signed [XY_W-1:0] ys;
   logic signed [Z_W-1:0]  angle;

   assign in_ready = !valid_ff || out_ready;
   assign xs       = $signed(in_data.x) >>> STAGE;
   assign ys       = $signed(in_data.y) >>> STAGE;
   assign angle    = ATAN_TAB[STAGE];

   always_comb begin
      data_in    = in_data;
      if (!in_data.y[XY_W-1]) begin
         data_in.x = in_data.x + ys;
         data_in.y = in_data.y - xs;
         data_in.z = in_data.z + angle;
      end else begin
         data_in.x = in_data.x - ys;
         data_in.y = in_data.y + xs;
         data_in.z = in_data.z - angle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

[rtl/gtg_post.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gtg_post: distance, bearing and speed law after the cordic chain
// Four registered stages; the last one is the result output register.
// ----------------------------------------------------------------------------
module gtg_post
   import gtg_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire cordic_type in_data,
   output logic            out_valid,
   input  wire logic       out_ready,
   output rsp_type         out_data
);

   localparam int NSTG = 4;

   logic [NSTG-1:0] v_ff;
   logic [NSTG-1:0] rdy;

   // stage 1: gain compensation product, bearing
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [BRG_W-1:0]  brg1_ff, brg1_in;
   logic signed [HD_W-1:0]   hd1_ff;
   logic signed [Z_W-1:0]    z_rnd;

   // stage 2: distance, heading error
   logic signed [PROD_W-1:0] dist_rnd;
   logic signed [PROD_W-33:0] dist_q;
   logic [SPD_W-1:0]         dist2_ff, dist2_in;
   logic signed [ERR_W-1:0]  err2_ff, err2_in;

   // stage 3: speed products, arrival compare
   logic [LINP_W-1:0]        linp3_ff, linp3_in;
   logic signed [ANGP_W-1:0] angp3_ff, angp3_in;
   logic signed [GAIN_W:0]   ag_s;
   logic                     reach3_ff, reach3_in;
   logic [SPD_W-1:0]         dist3_ff;

   // stage 4: rounding and caps
   logic [LINP_W:0]          lin_sum;
   logic [LINP_W-14:0]       lin_q;
   logic signed [ANGP_W:0]   ang_sum;
   logic signed [ANGP_W-17:0] ang_q;
   rsp_type                  out_ff, out_in;

   assign rdy[3]   = !v_ff[3] || out_ready;
   assign rdy[2]   = !v_ff[2] || rdy[3];
   assign rdy[1]   = !v_ff[1] || rdy[2];
   assign rdy[0]   = !v_ff[0] || rdy[1];
   assign in_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         if (rdy[1]) v_ff[1] <= v_ff[0];
         if (rdy[2]) v_ff[2] <= v_ff[1];
         if (rdy[3]) v_ff[3] <= v_ff[2];
      end
   end

   // stage 1
   assign prod_in = PROD_W'(in_data.x) * GAIN_COMP;
   assign z_rnd   = in_data.z + Z_W'(4);
   assign brg1_in = z_rnd[Z_W-1:3];

   // stage 2
   assign dist_rnd = prod_ff + DIST_RND;
   assign dist_q   = dist_rnd[PROD_W-1:32];

   always_comb begin
      if (dist_q[PROD_W-33]) begin
         dist2_in = '0;
      end else if (|dist_q[PROD_W-34:SPD_W]) begin
         dist2_in = '1;
      end else begin
         dist2_in = dist_q[SPD_W-1:0];
      end
   end

   assign err2_in = ERR_W'(brg1_ff) - ERR_W'(hd1_ff);

   // stage 3
   assign ag_s      = $signed({1'b0, cfg.angular_gain});
   assign linp3_in  = dist2_ff * cfg.linear_gain;
   assign angp3_in  = err2_ff * ag_s;
   assign reach3_in = (dist2_ff <= cfg.arrive_threshold);

   // stage 4
   assign lin_sum = {1'b0, linp3_ff} + (LINP_W + 1)'(8192);
   assign lin_q   = lin_sum[LINP_W:14];
   assign ang_sum = (ANGP_W + 1)'(angp3_ff) + (ANGP_W + 1)'(65536);
   assign ang_q   = ang_sum[ANGP_W:17];

   always_comb begin
      out_in          = '0;
      out_in.distance = dist3_ff;
      if (reach3_ff) begin
         out_in.reached = 1'b1;
      end else begin
         if (lin_q > (LINP_W - 13)'(cfg.speed_limit)) begin
            out_in.linear_speed = cfg.speed_limit;
         end else begin
            out_in.linear_speed = lin_q[SPD_W-1:0];
         end
         priority if (ang_q > $signed((ANGP_W - 16)'(cfg.speed_limit))) begin
            out_in.angular_speed = $signed({1'b0, cfg.speed_limit});
         end else if (ang_q < -(ANGP_W - 16)'(32768)) begin
            out_in.angular_speed = {1'b1, {(ANG_W-1){1'b0}}};
         end else begin
            out_in.angular_speed = ang_q[ANG_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && rdy[0]) begin
         prod_ff <= prod_in;
         brg1_ff <= brg1_in;
         hd1_ff  <= in_data.hd;
      end
      if (v_ff[0] && rdy[1]) begin
         dist2_ff <= dist2_in;
         err2_ff  <= err2_in;
      end
      if (v_ff[1] && rdy[2]) begin
         linp3_ff  <= linp3_in;
         angp3_ff  <= angp3_in;
         reach3_ff <= reach3_in;
         dist3_ff  <= dist2_ff;
      end
      if (v_ff[2] && rdy[3]) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = v_ff[3];
   assign out_data  = out_ff;

endmodule
`default_nettype wire

[rtl/go_to_goal_p_controller.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// go_to_goal_p_controller: proportional go-to-goal speed controller
// Pose in, speed command out; distance and bearing by a cordic cell chain.
// ----------------------------------------------------------------------------
// usage
//   req_bus: one pose beat (pos_x, pos_y, heading) per control tick
//   rsp_bus: one command beat (linear_speed, angular_speed, reached, distance)
//            per pose, in order
//   csr_*:   write-only settings; write goal, gains, speed limit and arrival
//            threshold only while no pose is in flight
// pipeline: pose beat to command beat through the entry register, one cell per
//   cordic stage and four post stages
// throughput: one pose per cycle while rsp_bus.ready stays high; each cordic cell
//   and post stage holds one beat and hands it on when the next stage is ready
// stall: every stage has its own valid bit, so bubbles collapse and poses keep
//   entering while a command waits in the output register; ready drops only
//   once every stage is full
// reset: empties the pipeline and restores the default goal and gains
// ----------------------------------------------------------------------------
module go_to_goal_p_controller
   import gtg_pkg::*;
#(
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   gtg_req_if.sink                   req_bus,
   gtg_rsp_if.source                 rsp_bus,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata
);

   // settings
   logic signed [POS_W-1:0] goal_x_ff;
   logic signed [POS_W-1:0] goal_y_ff;
   cfg_type                 cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff               <= 16'sd1536;
         goal_y_ff               <= 16'sd2253;
         cfg_ff.linear_gain      <= 16'd8192;
         cfg_ff.angular_gain     <= 16'd9830;
         cfg_ff.speed_limit      <= 15'd512;
         cfg_ff.arrive_threshold <= 15'd61;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GOAL_X:       goal_x_ff               <= csr_wdata;
            CSR_GOAL_Y:       goal_y_ff               <= csr_wdata;
            CSR_LINEAR_GAIN:  cfg_ff.linear_gain      <= csr_wdata;
            CSR_ANGULAR_GAIN: cfg_ff.angular_gain     <= csr_wdata;
            CSR_SPEED_LIMIT:  cfg_ff.speed_limit      <= csr_wdata[SPD_W-1:0];
            CSR_ARRIVE_THR:   cfg_ff.arrive_threshold <= csr_wdata[SPD_W-1:0];
            default: ;  // unknown index, write dropped
         endcase
      end
   end

   // entry stage: goal offset and pre-rotation into the right half plane
   logic signed [DIFF_W-1:0] dx, dy, ndx, ndy;
   logic                     ent_v_ff;
   logic                     ent_ready;
   cordic_type               ent_ff, ent_in;

   assign dx  = DIFF_W'(goal_x_ff) - DIFF_W'(req_bus.pos_x);
   assign dy  = DIFF_W'(goal_y_ff) - DIFF_W'(req_bus.pos_y);
   assign ndx = DIFF_W'(req_bus.pos_x) - DIFF_W'(goal_x_ff);
   assign ndy = DIFF_W'(req_bus.pos_y) - DIFF_W'(goal_y_ff);

   always_comb begin
      ent_in.hd = req_bus.heading;
      if (dx[DIFF_W-1]) begin
         // offset points left: turn by pi, start angle follows the sign of dy
         ent_in.x = {XY_W'(ndx), 8'd0} == '0 ? '0 : XY_W'(ndx) <<< 8;
         ent_in.y = XY_W'(ndy) <<< 8;
         ent_in.z = dy[DIFF_W-1] ? -PI_Q16 : PI_Q16;
      end else begin
         ent_in.x = XY_W'(dx) <<< 8;
         ent_in.y = XY_W'(dy) <<< 8;
         ent_in.z = '0;
      end
   end

   // cordic chain
   logic       cell_v   [CORDIC_STAGES+1];
   logic       cell_rdy [CORDIC_STAGES+1];
   cordic_type cell_d   [CORDIC_STAGES+1];

   assign ent_ready     = !ent_v_ff || cell_rdy[0];
   assign req_bus.ready = ent_ready;
   assign cell_v[0]     = ent_v_ff;
   assign cell_d[0]     = ent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_v_ff <= 1'b0;
      end else if (ent_ready) begin
         ent_v_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && ent_ready) begin
         ent_ff <= ent_in;
      end
   end

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      gtg_cordic_cell #(
         .STAGE (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cell_v[g]),
         .in_ready  (cell_rdy[g]),
         .in_data   (cell_d[g]),
         .out_valid (cell_v[g+1]),
         .out_ready (cell_rdy[g+1]),
         .out_data  (cell_d[g+1])
      );
   end

   // distance, bearing and speed law, ending in the output register
   rsp_type post_d;

   gtg_post u_post (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (cell_v[CORDIC_STAGES]),
      .in_ready  (cell_rdy[CORDIC_STAGES]),
      .in_data   (cell_d[CORDIC_STAGES]),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (post_d)
   );

   assign rsp_bus.linear_speed  = post_d.linear_speed;
   assign rsp_bus.angular_speed = post_d.angular_speed;
   assign rsp_bus.reached       = post_d.reached;
   assign rsp_bus.distance      = post_d.distance;

   // checks
   a_reached_stops : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.reached |->
         rsp_bus.linear_speed == '0 && rsp_bus.angular_speed == '0)
      else $error("reached beat carries nonzero speed");

   a_reached_matches : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |->
         rsp_bus.reached == (rsp_bus.distance <= cfg_ff.arrive_threshold))
      else $error("reached flag disagrees with distance");

   a_linear_capped : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> rsp_bus.linear_speed <= cfg_ff.speed_limit)
      else $error("linear speed above limit");

   a_full_when_blocked : assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> ent_v_ff && rsp_bus.valid && !rsp_bus.ready)
      else $error("input blocked while pipeline can move");

endmodule
`default_nettype wire
